>>> rtl/core/ipmi_serial_receive_deframer_core_assert.svh
// assertion macros shared by the deframer core
`ifndef IPMI_SERIAL_RECEIVE_DEFRAMER_CORE_ASSERT_SVH
`define IPMI_SERIAL_RECEIVE_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define ISRD_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ISRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/isrd_pkg.sv
// types and constants of the serial receive deframer
package isrd_pkg;

   localparam logic [2:0] MODE_LINK       = 3'd0;
   localparam logic [2:0] MODE_READ       = 3'd1;
   localparam logic [2:0] MODE_PTR_CLEAR  = 3'd2;
   localparam logic [2:0] MODE_ATTN_CLEAR = 3'd3;
   localparam logic [2:0] MODE_RELEASE    = 3'd4;

   localparam logic [7:0] MSG_END  = 8'hA0;
   localparam logic [7:0] CMD_END  = 8'hA1;
   localparam logic [7:0] ESC_BYTE = 8'hAA;
   localparam logic [7:0] ESC_BIT  = 8'h10;

   localparam int MSG_MIN_LEN = 4;

   typedef enum logic [3:0] {
      EV_NONE,
      EV_STORED,
      EV_OVERFLOW,
      EV_MSG_OK,
      EV_SHORT,
      EV_CHECKSUM,
      EV_IN_ESCAPE,
      EV_TOO_LONG,
      EV_CMD,
      EV_REFUSED,
      EV_EMPTY
   } isrd_event_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] link_byte;
   } isrd_item_type;

   typedef struct packed {
      logic [7:0]     read_data;
      isrd_event_type event_res;
      logic           attention;
      logic           link_ready;
   } isrd_result_type;

endpackage

>>> rtl/core/isrd_if.sv
// request, response and register write channels of the deframer
interface isrd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] link_byte;

   modport source (output valid, output mode, output link_byte, input ready);
   modport sink (input valid, input mode, input link_byte, output ready);
endinterface

interface isrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [3:0] event_res;
   logic       attention;
   logic       link_ready;

   modport source (output valid, output read_data, output event_res, output attention,
                   output link_ready, input ready);
   modport sink (input valid, input read_data, input event_res, input attention,
                 input link_ready, output ready);
endinterface

interface isrd_csr_if;
   logic valid;
   logic ready;
   logic h2b_irq_enable;

   modport source (output valid, output h2b_irq_enable, input ready);
   modport sink (input valid, input h2b_irq_enable, output ready);
endinterface

>>> rtl/core/ipmi_serial_receive_deframer_core.sv
// Serial receive deframer: takes one word per cycle, back to back, unless the result side stalls
// on rsp_bus.ready. A word is held in the input register, is decoded against the frame state in
// a single pass, and its result lands in the result register, from which it leaves. The frame store
// is a one-write, two-read memory: one read port keeps the last stored byte ready for checksum
// trimming and the other keeps the entry at the read pointer ready for message reads, so no word
// ever waits on the memory. The first two frame bytes live in flops for the swap. The store needs
// no clearing pass after reset. Write h2b_irq_enable only while idle; the core does not check it.
module ipmi_serial_receive_deframer_core
   import isrd_pkg::*;
#(
   parameter int FRAME_DEPTH = 256
) (
   input  logic          clock,
   input  logic          reset,
   isrd_req_if.sink      req_bus,
   isrd_rsp_if.source    rsp_bus,
   isrd_csr_if.sink      csr_bus
);

   logic            irq_en_ff;
   logic            in_valid_ff;
   isrd_item_type   in_item_ff;
   logic            out_valid_ff;
   isrd_result_type out_ff;
   isrd_result_type result;
   logic            proc;

   assign proc          = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || proc;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_en_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            irq_en_ff <= csr_bus.h2b_irq_enable;
         end
         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff <= 1'b1;
         end else if (proc) begin
            in_valid_ff <= 1'b0;
         end
         if (proc) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff.mode      <= req_bus.mode;
         in_item_ff.link_byte <= req_bus.link_byte;
      end
      if (proc) begin
         out_ff <= result;
      end
   end

   isrd_engine #(
      .FRAME_DEPTH(FRAME_DEPTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (proc),
      .item   (in_item_ff),
      .irq_en (irq_en_ff),
      .result (result)
   );

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.read_data  = out_ff.read_data;
   assign rsp_bus.event_res  = out_ff.event_res;
   assign rsp_bus.attention  = out_ff.attention;
   assign rsp_bus.link_ready = out_ff.link_ready;

endmodule

>>> rtl/core/isrd_engine.sv
// deframer state, frame memory and per-word decode
`include "ipmi_serial_receive_deframer_core_assert.svh"

module isrd_engine
   import isrd_pkg::*;
#(
   parameter int FRAME_DEPTH = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  isrd_item_type   item,
   input  logic            irq_en,
   output isrd_result_type result
);

   localparam int IW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int LW = $clog2(FRAME_DEPTH + 1);
   localparam logic [LW-1:0] DEPTH_L = LW'(FRAME_DEPTH);
   localparam logic [LW-1:0] MIN_L   = LW'(MSG_MIN_LEN);

   logic [7:0] mem [FRAME_DEPTH];

   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic          esc_ff, esc_in;
   logic          ovf_ff, ovf_in;
   logic          wait_ff, wait_in;
   logic          attn_ff, attn_in;
   logic          ptr_none_ff, ptr_none_in;
   logic [LW-1:0] ptr_ff, ptr_in;
   // entries 0 and 1 live in flops so a message end can swap them
   logic [7:0]    b0_ff, b0_in;
   logic [7:0]    b1_ff, b1_in;
   // prefetched store[len-1] and store[read pointer]
   logic [7:0]    tail_ff;
   logic [7:0]    head_ff;

   logic          we;
   logic [IW-1:0] waddr;
   logic [7:0]    wdata;
   logic [IW-1:0] raddr_tail;
   logic [IW-1:0] raddr_head;
   logic [LW-1:0] len_m1;
   logic [7:0]    ch_eff;
   logic [7:0]    head_val;
   logic [7:0]    data;
   isrd_event_type ev;

   assign ch_eff = esc_ff ? (item.link_byte & ~ESC_BIT) : item.link_byte;
   assign head_val = (ptr_ff == '0) ? b0_ff :
                     (ptr_ff == LW'(1)) ? b1_ff : head_ff;

   always_comb begin
      len_in      = len_ff;
      sum_in      = sum_ff;
      esc_in      = esc_ff;
      ovf_in      = ovf_ff;
      wait_in     = wait_ff;
      attn_in     = attn_ff;
      ptr_none_in = ptr_none_ff;
      ptr_in      = ptr_ff;
      b0_in       = b0_ff;
      b1_in       = b1_ff;
      we          = 1'b0;
      waddr       = len_ff[IW-1:0];
      wdata       = ch_eff;
      data        = 8'd0;
      ev          = EV_NONE;
      if (fire) begin
         unique case (item.mode)
            MODE_LINK: begin
               if (wait_ff) begin
                  ev = EV_REFUSED;
               end else if (item.link_byte == MSG_END || item.link_byte == CMD_END) begin
                  if (esc_ff) begin
                     ev = EV_IN_ESCAPE;
                  end else if (ovf_ff) begin
                     ev = EV_TOO_LONG;
                  end else if (len_ff == '0) begin
                     ev = EV_EMPTY;
                  end else if (item.link_byte == MSG_END) begin
                     attn_in = 1'b1;
                     if (len_ff < MIN_L) begin
                        ev = EV_SHORT;
                     end else if (sum_ff != 8'd0) begin
                        ev = EV_CHECKSUM;
                     end else begin
                        // drop the checksum byte and swap the first two bytes
                        ev     = EV_MSG_OK;
                        len_in = len_ff - LW'(1);
                        sum_in = sum_ff - tail_ff;
                        b0_in  = b1_ff;
                        b1_in  = b0_ff;
                        if (irq_en) begin
                           wait_in = 1'b1;
                        end
                     end
                  end else begin
                     ev     = EV_CMD;
                     len_in = '0;
                     sum_in = 8'd0;
                     esc_in = 1'b0;
                     ovf_in = 1'b0;
                  end
               end else if (item.link_byte == ESC_BYTE) begin
                  if (!ovf_ff) begin
                     esc_in = 1'b1;
                  end
               end else begin
                  esc_in = 1'b0;
                  if (ovf_ff) begin
                     ev = EV_OVERFLOW;
                  end else if (len_ff >= DEPTH_L) begin
                     ev     = EV_OVERFLOW;
                     ovf_in = 1'b1;
                  end else begin
                     ev     = EV_STORED;
                     we     = 1'b1;
                     len_in = len_ff + LW'(1);
                     sum_in = sum_ff + ch_eff;
                     if (len_ff == '0) begin
                        b0_in = ch_eff;
                     end
                     if (len_ff == LW'(1)) begin
                        b1_in = ch_eff;
                     end
                  end
               end
            end
            MODE_READ: begin
               if (ptr_none_ff) begin
                  data        = 8'(len_ff);
                  ptr_none_in = 1'b0;
                  ptr_in      = '0;
               end else if (ptr_ff < len_ff && ptr_ff < DEPTH_L) begin
                  data   = head_val;
                  ptr_in = ptr_ff + LW'(1);
               end
            end
            MODE_PTR_CLEAR: begin
               ptr_none_in = 1'b1;
               ptr_in      = '0;
            end
            MODE_ATTN_CLEAR: begin
               attn_in = 1'b0;
            end
            MODE_RELEASE: begin
               wait_in = 1'b0;
               len_in  = '0;
               sum_in  = 8'd0;
               esc_in  = 1'b0;
               ovf_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign len_m1     = len_in - LW'(1);
   assign raddr_tail = len_m1[IW-1:0];
   assign raddr_head = ptr_in[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         sum_ff      <= 8'd0;
         esc_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
         wait_ff     <= 1'b0;
         attn_ff     <= 1'b0;
         ptr_none_ff <= 1'b1;
         ptr_ff      <= '0;
      end else begin
         len_ff      <= len_in;
         sum_ff      <= sum_in;
         esc_ff      <= esc_in;
         ovf_ff      <= ovf_in;
         wait_ff     <= wait_in;
         attn_ff     <= attn_in;
         ptr_none_ff <= ptr_none_in;
         ptr_ff      <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff <= b0_in;
      b1_ff <= b1_in;
   end

   // one write port, two registered read ports with write bypass
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      tail_ff <= (we && waddr == raddr_tail) ? wdata : mem[raddr_tail];
      head_ff <= (we && waddr == raddr_head) ? wdata : mem[raddr_head];
   end

   assign result.read_data  = data;
   assign result.event_res  = ev;
   assign result.attention  = attn_in;
   assign result.link_ready = ~wait_in;

   `ISRD_ASSERT_HOLDS(a_ovf_full, clock, reset, ovf_ff, len_ff == DEPTH_L, "overflow below full")
   `ISRD_ASSERT_HOLDS(a_wait_len, clock, reset, wait_ff, len_ff >= LW'(3), "waiting with short frame")
   `ISRD_ASSERT_HOLDS(a_ptr_range, clock, reset, !ptr_none_ff, ptr_ff <= DEPTH_L, "read pointer past depth")
   `ISRD_ASSERT_NEXT(a_msg_attn, clock, reset, fire && ev == EV_MSG_OK, attn_ff, "message end without attention")

endmodule

>>> tb/tb_ipmi_serial_receive_deframer_core.sv
// self-checking testbench for the serial receive deframer core
`timescale 1ns / 1ps

module tb_ipmi_serial_receive_deframer_core;
   import isrd_pkg::*;

   localparam int FRAME_DEPTH = 256;
   localparam logic [9:0] PTR_IDLE = 10'h3FF;
   // encodings above MODE_RELEASE do nothing
   localparam logic [2:0] MODE_TOP = 3'd7;
   localparam int RANDOM_WORDS = 750;
   localparam int PHASES = 8;

   // expected-result store with its own copy of the frame state
   class deframer_scoreboard;
      logic [7:0] frame_mem [FRAME_DEPTH];
      logic [8:0] frame_len;
      logic [9:0] read_ptr;
      logic [7:0] byte_sum;
      bit esc_pending;
      bit overflow_seen;
      bit awaiting_release;
      bit attn;
      bit irq_en;
      isrd_result_type pending_results[$];
      int errors;

      function new();
         clear_frame();
         read_ptr = PTR_IDLE;
         awaiting_release = 1'b0;
         attn = 1'b0;
         irq_en = 1'b0;
         errors = 0;
      endfunction

      function void clear_frame();
         esc_pending = 1'b0;
         overflow_seen = 1'b0;
         frame_len = '0;
         byte_sum = '0;
      endfunction

      function void note_word(input logic [2:0] mode, input logic [7:0] link_byte);
         isrd_result_type r;
         logic [7:0] ch;
         logic [7:0] t;
         r = '0;
         r.event_res = EV_NONE;
         ch = link_byte;
         case (mode)
            MODE_LINK: begin
               if (awaiting_release) begin
                  r.event_res = EV_REFUSED;
               end else if (ch == MSG_END || ch == CMD_END) begin
                  if (esc_pending) begin
                     r.event_res = EV_IN_ESCAPE;
                  end else if (overflow_seen) begin
                     r.event_res = EV_TOO_LONG;
                  end else if (frame_len == 0) begin
                     r.event_res = EV_EMPTY;
                  end else if (ch == CMD_END) begin
                     clear_frame();
                     r.event_res = EV_CMD;
                  end else begin
                     attn = 1'b1;
                     if (frame_len < MSG_MIN_LEN) begin
                        r.event_res = EV_SHORT;
                     end else if (byte_sum != 0) begin
                        r.event_res = EV_CHECKSUM;
                     end else begin
                        // drop the checksum byte, swap the first two
                        frame_len = frame_len - 1'b1;
                        byte_sum = byte_sum - frame_mem[frame_len];
                        t = frame_mem[0];
                        frame_mem[0] = frame_mem[1];
                        frame_mem[1] = t;
                        if (irq_en) awaiting_release = 1'b1;
                        r.event_res = EV_MSG_OK;
                     end
                  end
               end else if (ch == ESC_BYTE) begin
                  if (!overflow_seen) esc_pending = 1'b1;
               end else begin
                  if (esc_pending) begin
                     esc_pending = 1'b0;
                     ch = ch & ~ESC_BIT;
                  end
                  if (overflow_seen) begin
                     r.event_res = EV_OVERFLOW;
                  end else if (frame_len >= FRAME_DEPTH) begin
                     overflow_seen = 1'b1;
                     r.event_res = EV_OVERFLOW;
                  end else begin
                     frame_mem[frame_len] = ch;
                     frame_len = frame_len + 1'b1;
                     byte_sum = byte_sum + ch;
                     r.event_res = EV_STORED;
                  end
               end
            end
            MODE_READ: begin
               if (read_ptr == PTR_IDLE) begin
                  r.read_data = frame_len[7:0];
                  read_ptr = '0;
               end else if (read_ptr < frame_len && read_ptr < FRAME_DEPTH) begin
                  r.read_data = frame_mem[read_ptr];
                  read_ptr = read_ptr + 1'b1;
               end
            end
            MODE_PTR_CLEAR: read_ptr = PTR_IDLE;
            MODE_ATTN_CLEAR: attn = 1'b0;
            MODE_RELEASE: begin
               awaiting_release = 1'b0;
               clear_frame();
            end
            default: ;
         endcase
         r.attention = attn;
         r.link_ready = !awaiting_release;
         pending_results.push_back(r);
      endfunction

      task report(input string what, input logic [7:0] got, input logic [7:0] want);
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_word(input isrd_result_type got);
         isrd_result_type want;
         if (pending_results.size() == 0) begin
            report("word with none expected, event", {4'b0, got.event_res}, 8'h00);
         end else begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
               report("read_data", got.read_data, want.read_data);
            if (got.event_res !== want.event_res)
               report("event_res", {4'b0, got.event_res}, {4'b0, want.event_res});
            if (got.attention !== want.attention)
               report("attention", {7'b0, got.attention}, {7'b0, want.attention});
            if (got.link_ready !== want.link_ready)
               report("link_ready", {7'b0, got.link_ready}, {7'b0, want.link_ready});
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit gaps_on = 1'b1;
   int words_sent = 0;
   deframer_scoreboard sb = new();

   isrd_req_if req_bus();
   isrd_rsp_if rsp_bus();
   isrd_csr_if csr_bus();

   ipmi_serial_receive_deframer_core #(.FRAME_DEPTH(FRAME_DEPTH)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_word({rsp_bus.read_data, rsp_bus.event_res, rsp_bus.attention,
                        rsp_bus.link_ready});
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_word(input logic [2:0] mode, input logic [7:0] link_byte);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.link_byte <= link_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_word(mode, link_byte);
      words_sent++;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   task automatic write_irq_enable(input logic value);
      csr_bus.valid <= 1'b1;
      csr_bus.h2b_irq_enable <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      sb.irq_en = value;
   endtask

   function automatic logic [7:0] pick_marker();
      case ($urandom_range(0, 2))
         0: return MSG_END;
         1: return CMD_END;
         default: return ESC_BYTE;
      endcase
   endfunction

   // markers always go escaped, other bytes with bit 4 clear sometimes
   task automatic send_frame(input logic [7:0] body[$], input logic [7:0] closer,
                             input bit closed);
      foreach (body[i]) begin
         if (body[i] == MSG_END || body[i] == CMD_END || body[i] == ESC_BYTE ||
             ((body[i] & ESC_BIT) == 0 && $urandom_range(0, 7) == 0)) begin
            send_word(MODE_LINK, ESC_BYTE);
            send_word(MODE_LINK, body[i] | ESC_BIT);
         end else begin
            send_word(MODE_LINK, body[i]);
         end
      end
      if (closed) send_word(MODE_LINK, closer);
   endtask

   task automatic random_exchange();
      logic [7:0] body[$];
      logic [7:0] sum;
      logic [7:0] b;
      int n;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 14);
         sum = '0;
         for (int i = 0; i < n; i++) begin
            b = ($urandom_range(0, 3) == 0) ? pick_marker() : 8'($urandom);
            body.push_back(b);
            sum = sum + b;
         end
         if (n > 0 && $urandom_range(0, 3) != 0) body[n - 1] = body[n - 1] - sum;
         pick = $urandom_range(0, 99);
         send_frame(body, (pick < 85) ? MSG_END : CMD_END, pick < 94);
         if ($urandom_range(0, 4) < 3) begin
            if ($urandom_range(0, 3) != 0) send_word(MODE_PTR_CLEAR, 8'($urandom));
            repeat (n + 2) send_word(MODE_READ, 8'($urandom));
         end
         if ($urandom_range(0, 1)) send_word(MODE_ATTN_CLEAR, 8'($urandom));
         if (sb.awaiting_release) begin
            repeat ($urandom_range(0, 3)) send_word(MODE_LINK, 8'($urandom));
            if ($urandom_range(0, 4) != 0) send_word(MODE_RELEASE, 8'($urandom));
         end
      end else begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) begin
               b = ($urandom_range(0, 2) == 0) ? pick_marker() : 8'($urandom);
               send_word(MODE_LINK, b);
            end else begin
               send_word(3'($urandom_range(MODE_READ, MODE_TOP)), 8'($urandom));
            end
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [7:0] b;
      logic [7:0] good_body[$];
      int random_base;
      good_body = '{MSG_END, ESC_BYTE, 8'h5C, 8'h5A};
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_LINK;
      req_bus.link_byte <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.h2b_irq_enable <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, empty ends, escapes, short, bad sum, good message
      send_word(MODE_READ, 8'h00);
      send_word(MODE_READ, 8'hFF);
      send_word(MODE_PTR_CLEAR, 8'h00);
      send_word(MODE_LINK, MSG_END);
      send_word(MODE_LINK, CMD_END);
      send_word(MODE_LINK, ESC_BYTE);
      send_word(MODE_LINK, MSG_END);
      send_word(MODE_LINK, 8'hFF);
      send_word(MODE_LINK, 8'h00);
      send_word(MODE_LINK, MSG_END);
      send_word(MODE_LINK, 8'h11);
      send_word(MODE_LINK, 8'h01);
      send_word(MODE_LINK, MSG_END);
      send_word(MODE_LINK, CMD_END);
      send_frame(good_body, MSG_END, 1'b1);
      send_word(MODE_PTR_CLEAR, 8'h00);
      repeat (5) send_word(MODE_READ, 8'h00);
      send_word(MODE_ATTN_CLEAR, 8'h00);
      send_word(MODE_RELEASE, 8'h00);
      send_word(MODE_TOP, 8'hFF);

      // full buffer: the length byte read back wraps to zero, then overflow handling
      wait_for_results();
      repeat (FRAME_DEPTH) begin
         do b = 8'($urandom); while (b == MSG_END || b == CMD_END || b == ESC_BYTE);
         send_word(MODE_LINK, b);
      end
      send_word(MODE_PTR_CLEAR, 8'h00);
      repeat (3) send_word(MODE_READ, 8'h00);
      send_word(MODE_LINK, ESC_BYTE);
      send_word(MODE_LINK, 8'hB5);
      send_word(MODE_LINK, ESC_BYTE);
      send_word(MODE_LINK, MSG_END);
      send_word(MODE_LINK, CMD_END);
      send_word(MODE_LINK, 8'h42);
      send_word(MODE_RELEASE, 8'h00);

      random_base = words_sent;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         write_irq_enable(phase % 2 == 0);
         gaps_on = (phase < PHASES - 2) && (phase != 3);
         while (words_sent < random_base + (phase + 1) * RANDOM_WORDS / PHASES)
            random_exchange();
      end

      wait_for_results();
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/isrd_pkg.sv
rtl/core/isrd_if.sv
rtl/core/isrd_engine.sv
rtl/core/ipmi_serial_receive_deframer_core.sv
tb/tb_ipmi_serial_receive_deframer_core.sv
